// File: design/lpcp_pkg.sv
`default_nettype none

package lpcp_pkg;

  localparam int ADDR_W     = 19;
  localparam int STORE_DEPTH = 524288;
  localparam int PIX_W      = 8;
  localparam int PT_W       = 32;
  localparam int CNT_W      = 24;
  localparam int U_W        = 18;
  localparam int V_W        = 17;
  localparam int INT_W      = 16;
  localparam int CFG_N      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Projection arithmetic: Q.20 image coordinates, 64-bit numerators.
  localparam int FRAC_W = 20;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 23;
  localparam int QB     = 34;
  localparam int DIV_LAT = QB + 1;
  localparam int UV_W   = QB + 2;
  localparam int UQ_W   = 33;

  localparam logic signed [PT_W-1:0] DEPTH_LO = 32'sd327680;
  localparam logic signed [PT_W-1:0] DEPTH_HI = 32'sd4587520;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [U_W-1:0]   U_MAX   = '1;
  localparam logic [V_W-1:0]   V_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5,
    REG_FOCAL  = 3'd6,
    REG_CENTER = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET [CFG_N] = '{
    64'd16777216, 64'd0, 64'd72057594037927936, 64'd0,
    64'd0, 64'd16777216, 64'd4503599628419072, 64'd0
  };

endpackage

`default_nettype wire

// File: design/lpcp_if.sv
`default_nettype none

interface lpcp_cfg_if;
  import lpcp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface lpcp_in_if;
  import lpcp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic                   first_point;
  logic [ADDR_W-1:0]      pixel_addr;
  logic [PIX_W-1:0]       pixel_value;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_z;
  modport source (output valid, action, first_point, pixel_addr, pixel_value,
                  point_x, point_y, point_z, input ready);
  modport sink (input valid, action, first_point, pixel_addr, pixel_value,
                point_x, point_y, point_z, output ready);
endinterface

interface lpcp_out_if;
  import lpcp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   in_view;
  logic [U_W-1:0]         u_coord;
  logic [V_W-1:0]         v_coord;
  logic signed [PT_W-1:0] cam_x;
  logic signed [PT_W-1:0] cam_y;
  logic signed [PT_W-1:0] cam_z;
  logic [INT_W-1:0]       intensity;
  logic [CNT_W-1:0]       view_count;
  modport source (output valid, in_view, u_coord, v_coord, cam_x, cam_y, cam_z,
                  intensity, view_count, input ready);
  modport sink (input valid, in_view, u_coord, v_coord, cam_x, cam_y, cam_z,
                intensity, view_count, output ready);
endinterface

`default_nettype wire

// File: design/lpcp_ram.sv
`default_nettype none

module lpcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/lpcp_div.sv
`default_nettype none

module lpcp_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [lpcp_pkg::NUM_W-1:0] num,
  input  logic [lpcp_pkg::DEN_W-1:0]     den,
  output logic signed [lpcp_pkg::QB:0]   quot,
  output logic                           ovf
);
  import lpcp_pkg::*;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    lo;
    logic [QB-1:0]    q;
  } dstg_t;

  dstg_t st_r [QB+1];

  function automatic dstg_t div_step(input dstg_t s);
    dstg_t          n;
    logic [DEN_W:0] trial;
    logic           ge;
    n     = s;
    trial = {s.rem, s.lo[QB-1]};
    ge    = trial >= {1'b0, s.den};
    n.rem = ge ? DEN_W'(trial - {1'b0, s.den}) : trial[DEN_W-1:0];
    n.lo  = {s.lo[QB-2:0], 1'b0};
    n.q   = {s.q[QB-2:0], ge};
    return n;
  endfunction

  logic [NUM_W-1:0]    mag;
  logic [NUM_W-QB-1:0] hi;
  dstg_t               init;

  // Quotients of 2^34 or more cannot land in the image and are only flagged.
  always_comb begin
    mag       = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    hi        = mag[NUM_W-1:QB];
    init.neg  = num[NUM_W-1];
    init.ovf  = hi >= (NUM_W-QB)'(den);
    init.den  = den;
    init.rem  = init.ovf ? '0 : DEN_W'(hi);
    init.lo   = mag[QB-1:0];
    init.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= init;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= div_step(st_r[k]);
      end
    end
  end

  assign quot = st_r[QB].neg ? -$signed({1'b0, st_r[QB].q}) : $signed({1'b0, st_r[QB].q});
  assign ovf  = st_r[QB].ovf;

endmodule

`default_nettype wire

// File: design/lidar_point_camera_projection.sv
`default_nettype none
// Channel  | Dir | Handshake    | Carries
// cfg_ch   | in  | valid/ready  | register index, 64-bit write data
// in_ch    | in  | valid/ready  | one request: pixel write or lidar point
// out_ch   | out | valid/ready  | one result per request
//
// One request enters per cycle while the output is not stalled; each result passes
// through the transform multiply, sum, focal multiply, 35-stage divider, then
// bounds, address, image read, weights and blend. rst_n is synchronous and
// clears the valid bits, the in-view count and the configuration registers; the
// image store is not cleared. A stalled output freezes the whole pipeline.

module lidar_point_camera_projection #(
  parameter int IMG_W = 1024,
  parameter int IMG_H = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  lpcp_cfg_if.sink   cfg_ch,
  lpcp_in_if.sink    in_ch,
  lpcp_out_if.source out_ch
);
  import lpcp_pkg::*;

  localparam int XW = $clog2(IMG_W);
  localparam int YW = $clog2(IMG_H);
  localparam logic [UV_W-2:0]  U_LIM  = (UV_W-1)'(IMG_W) << FRAC_W;
  localparam logic [UV_W-2:0]  V_LIM  = (UV_W-1)'(IMG_H) << FRAC_W;
  localparam logic [12:0]      X_LAST = 13'(IMG_W - 1);
  localparam logic [12:0]      Y_LAST = 13'(IMG_H - 1);
  localparam logic [ADDR_W-1:0] ROW_W = ADDR_W'(IMG_W);
  localparam logic [FRAC_W:0]  ONE_F  = (FRAC_W+1)'(1) << FRAC_W;

  typedef struct packed {
    logic                   action;
    logic                   first;
    logic [ADDR_W-1:0]      addr;
    logic [PIX_W-1:0]       pval;
    logic signed [PT_W-1:0] cam_x;
    logic signed [PT_W-1:0] cam_y;
    logic signed [PT_W-1:0] cam_z;
    logic                   depth_ok;
  } side_t;

  function automatic logic signed [PT_W-1:0] cam_row(
    input logic signed [63:0] pa, input logic signed [63:0] pb,
    input logic signed [63:0] pc, input logic signed [31:0] t);
    logic signed [58:0] acc;
    logic signed [58:0] rnd;
    logic signed [PT_W-1:0] res;
    acc = 59'(pa >>> 8) + 59'(pb >>> 8) + 59'(pc >>> 8) + (59'(t) <<< 8);
    rnd = (acc + 59'sd32768) >>> 16;
    if (rnd > 59'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (rnd < -59'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = PT_W'(rnd);
    end
    return res;
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] cfg_r [CFG_N];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_N; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_ch.valid) begin
      cfg_r[cfg_ch.index] <= cfg_ch.data;
    end
  end

  logic [CFG_DATA_W-1:0] row_a [3];
  logic [CFG_DATA_W-1:0] row_b [3];
  assign row_a[0] = cfg_r[REG_ROW0_A];
  assign row_a[1] = cfg_r[REG_ROW1_A];
  assign row_a[2] = cfg_r[REG_ROW2_A];
  assign row_b[0] = cfg_r[REG_ROW0_B];
  assign row_b[1] = cfg_r[REG_ROW1_B];
  assign row_b[2] = cfg_r[REG_ROW2_B];

  logic en;
  logic o_vld_r;
  assign en          = !o_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: rotation products.
  logic               s1_vld_r;
  side_t              s1_side_r;
  logic signed [63:0] s1_p_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r.action <= in_ch.action;
      s1_side_r.first  <= in_ch.first_point;
      s1_side_r.addr   <= in_ch.pixel_addr;
      s1_side_r.pval   <= in_ch.pixel_value;
      s1_side_r.cam_x  <= '0;
      s1_side_r.cam_y  <= '0;
      s1_side_r.cam_z  <= '0;
      s1_side_r.depth_ok <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        s1_p_r[r][0] <= $signed(row_a[r][31:0]) * in_ch.point_x;
        s1_p_r[r][1] <= $signed(row_a[r][63:32]) * in_ch.point_y;
        s1_p_r[r][2] <= $signed(row_b[r][31:0]) * in_ch.point_z;
      end
    end
  end

  // Stage 2: camera frame point.
  logic  s2_vld_r;
  side_t s2_side_r;
  side_t s2_side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_comb begin
    s2_side_nxt       = s1_side_r;
    s2_side_nxt.cam_x = cam_row(s1_p_r[0][0], s1_p_r[0][1], s1_p_r[0][2],
                                $signed(row_b[0][63:32]));
    s2_side_nxt.cam_y = cam_row(s1_p_r[1][0], s1_p_r[1][1], s1_p_r[1][2],
                                $signed(row_b[1][63:32]));
    s2_side_nxt.cam_z = cam_row(s1_p_r[2][0], s1_p_r[2][1], s1_p_r[2][2],
                                $signed(row_b[2][63:32]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r <= s2_side_nxt;
    end
  end

  // Stage 3: focal products and depth window.
  logic               s3_vld_r;
  side_t              s3_side_r;
  side_t              s3_side_nxt;
  logic signed [63:0] s3_nu_r;
  logic signed [63:0] s3_nv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_comb begin
    s3_side_nxt          = s2_side_r;
    s3_side_nxt.depth_ok = s2_side_r.cam_z >= DEPTH_LO && s2_side_r.cam_z <= DEPTH_HI;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s3_side_nxt;
      s3_nu_r <= $signed({1'b0, cfg_r[REG_FOCAL][31:0]}) * s2_side_r.cam_x;
      s3_nv_r <= $signed({1'b0, cfg_r[REG_FOCAL][63:32]}) * s2_side_r.cam_y;
    end
  end

  // Dividers, with the request carried alongside.
  logic signed [QB:0] qu;
  logic signed [QB:0] qv;
  logic               ovf_u;
  logic               ovf_v;

  lpcp_div u_div_u (
    .clk  (clk),
    .en   (en),
    .num  (s3_nu_r),
    .den  (s3_side_r.cam_z[DEN_W-1:0]),
    .quot (qu),
    .ovf  (ovf_u)
  );

  lpcp_div u_div_v (
    .clk  (clk),
    .en   (en),
    .num  (s3_nv_r),
    .den  (s3_side_r.cam_z[DEN_W-1:0]),
    .quot (qv),
    .ovf  (ovf_v)
  );

  logic  dl_vld_r  [DIV_LAT];
  side_t dl_side_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      dl_vld_r[0] <= s3_vld_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_vld_r[i] <= dl_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_side_r[0] <= s3_side_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_side_r[i] <= dl_side_r[i-1];
      end
    end
  end

  // Stage E: principal point and bounds.
  side_t             d_side;
  logic [UV_W-1:0]   u_full;
  logic [UV_W-1:0]   v_full;
  logic              view_d;

  assign d_side = dl_side_r[DIV_LAT-1];
  assign u_full = UV_W'(qu) + UV_W'(cfg_r[REG_CENTER][31:0]);
  assign v_full = UV_W'(qv) + UV_W'(cfg_r[REG_CENTER][63:32]);
  assign view_d = d_side.action && d_side.depth_ok && !ovf_u && !ovf_v &&
                  !u_full[UV_W-1] && u_full[UV_W-2:0] <= U_LIM &&
                  !v_full[UV_W-1] && v_full[UV_W-2:0] <= V_LIM;

  logic             e_vld_r;
  side_t            e_side_r;
  logic             e_view_r;
  logic [UQ_W-1:0]  e_u_r;
  logic [UQ_W-1:0]  e_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= dl_vld_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r <= d_side;
      e_view_r <= view_d;
      e_u_r    <= u_full[UQ_W-1:0];
      e_v_r    <= v_full[UQ_W-1:0];
    end
  end

  // Stage F: in-view count, cell selection and row offsets.
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_base = (e_side_r.action && e_side_r.first) ? '0 : cnt_r;
    cnt_nxt  = (e_view_r && cnt_base != CNT_MAX) ? cnt_base + 1'b1 : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (en && e_vld_r) begin
      cnt_r <= cnt_nxt;
    end
  end

  logic [12:0]       x_raw;
  logic [12:0]       y_raw;
  logic [XW-1:0]     x0;
  logic [XW-1:0]     x1;
  logic [YW-1:0]     y0;
  logic [YW-1:0]     y1;
  logic [20:0]       uq_raw;
  logic [20:0]       vq_raw;

  always_comb begin
    x_raw  = e_u_r[UQ_W-1:FRAC_W];
    y_raw  = e_v_r[UQ_W-1:FRAC_W];
    x0     = (x_raw > X_LAST) ? XW'(X_LAST) : XW'(x_raw);
    y0     = (y_raw > Y_LAST) ? YW'(Y_LAST) : YW'(y_raw);
    x1     = (13'(x0) == X_LAST) ? x0 : x0 + 1'b1;
    y1     = (13'(y0) == Y_LAST) ? y0 : y0 + 1'b1;
    uq_raw = e_u_r[UQ_W-1:12];
    vq_raw = e_v_r[UQ_W-1:12];
  end

  logic              f_vld_r;
  side_t             f_side_r;
  logic              f_view_r;
  logic [CNT_W-1:0]  f_cnt_r;
  logic [U_W-1:0]    f_uq_r;
  logic [V_W-1:0]    f_vq_r;
  logic [XW-1:0]     f_x0_r;
  logic [XW-1:0]     f_x1_r;
  logic [ADDR_W-1:0] f_y0w_r;
  logic [ADDR_W-1:0] f_y1w_r;
  logic [FRAC_W-1:0] f_dx_r;
  logic [FRAC_W-1:0] f_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_side_r <= e_side_r;
      f_view_r <= e_view_r;
      f_cnt_r  <= cnt_nxt;
      f_uq_r   <= (uq_raw > 21'(U_MAX)) ? U_MAX : U_W'(uq_raw);
      f_vq_r   <= (vq_raw > 21'(V_MAX)) ? V_MAX : V_W'(vq_raw);
      f_x0_r   <= x0;
      f_x1_r   <= x1;
      f_y0w_r  <= ADDR_W'(y0) * ROW_W;
      f_y1w_r  <= ADDR_W'(y1) * ROW_W;
      f_dx_r   <= e_u_r[FRAC_W-1:0];
      f_dy_r   <= e_v_r[FRAC_W-1:0];
    end
  end

  // Stage G: image store access and bilinear weights. The store is kept as
  // four identical copies so that all four neighbors read in the same cycle.
  // Pixel writes land at this same stage, so reads and writes stay in order.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_ra [4];
  logic [PIX_W-1:0]  ram_rd [4];
  logic [FRAC_W:0]   wx [2];
  logic [FRAC_W:0]   wy [2];

  assign ram_we    = en && f_vld_r && !f_side_r.action;
  assign ram_ra[0] = f_y0w_r + ADDR_W'(f_x0_r);
  assign ram_ra[1] = f_y0w_r + ADDR_W'(f_x1_r);
  assign ram_ra[2] = f_y1w_r + ADDR_W'(f_x0_r);
  assign ram_ra[3] = f_y1w_r + ADDR_W'(f_x1_r);
  assign wx[0]     = ONE_F - (FRAC_W+1)'(f_dx_r);
  assign wx[1]     = (FRAC_W+1)'(f_dx_r);
  assign wy[0]     = ONE_F - (FRAC_W+1)'(f_dy_r);
  assign wy[1]     = (FRAC_W+1)'(f_dy_r);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    lpcp_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (f_side_r.addr),
      .wdata (f_side_r.pval),
      .re    (en),
      .raddr (ram_ra[k]),
      .rdata (ram_rd[k])
    );
  end

  logic                  g_vld_r;
  side_t                 g_side_r;
  logic                  g_view_r;
  logic [CNT_W-1:0]      g_cnt_r;
  logic [U_W-1:0]        g_uq_r;
  logic [V_W-1:0]        g_vq_r;
  logic [2*FRAC_W+1:0]   g_w_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_side_r <= f_side_r;
      g_view_r <= f_view_r;
      g_cnt_r  <= f_cnt_r;
      g_uq_r   <= f_uq_r;
      g_vq_r   <= f_vq_r;
      for (int k = 0; k < 4; k++) begin
        g_w_r[k] <= (2*FRAC_W+2)'(wy[k/2]) * (2*FRAC_W+2)'(wx[k%2]);
      end
    end
  end

  // Stage H: weighted pixels.
  logic                  h_vld_r;
  side_t                 h_side_r;
  logic                  h_view_r;
  logic [CNT_W-1:0]      h_cnt_r;
  logic [U_W-1:0]        h_uq_r;
  logic [V_W-1:0]        h_vq_r;
  logic [2*FRAC_W+9:0]   h_p_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_side_r <= g_side_r;
      h_view_r <= g_view_r;
      h_cnt_r  <= g_cnt_r;
      h_uq_r   <= g_uq_r;
      h_vq_r   <= g_vq_r;
      for (int k = 0; k < 4; k++) begin
        h_p_r[k] <= (2*FRAC_W+10)'(g_w_r[k]) * (2*FRAC_W+10)'(ram_rd[k]);
      end
    end
  end

  // Output register: blend and round. The weighted sum carries 40 fraction
  // bits; dropping 32 of them leaves Q8.8.
  logic [2*FRAC_W+11:0] blend;
  logic [INT_W-1:0]     itn;

  assign blend = (2*FRAC_W+12)'(h_p_r[0]) + (2*FRAC_W+12)'(h_p_r[1]) +
                 (2*FRAC_W+12)'(h_p_r[2]) + (2*FRAC_W+12)'(h_p_r[3]) +
                 (2*FRAC_W+12)'(32'h80000000);
  assign itn   = blend[2*FRAC_W-8+INT_W-1:2*FRAC_W-8];

  logic                   o_view_r;
  logic [U_W-1:0]         o_u_r;
  logic [V_W-1:0]         o_v_r;
  logic signed [PT_W-1:0] o_cx_r;
  logic signed [PT_W-1:0] o_cy_r;
  logic signed [PT_W-1:0] o_cz_r;
  logic [INT_W-1:0]       o_int_r;
  logic [CNT_W-1:0]       o_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_view_r <= h_view_r;
      o_u_r    <= h_view_r ? h_uq_r : '0;
      o_v_r    <= h_view_r ? h_vq_r : '0;
      o_int_r  <= h_view_r ? itn : '0;
      o_cx_r   <= h_side_r.action ? h_side_r.cam_x : '0;
      o_cy_r   <= h_side_r.action ? h_side_r.cam_y : '0;
      o_cz_r   <= h_side_r.action ? h_side_r.cam_z : '0;
      o_cnt_r  <= h_cnt_r;
    end
  end

  assign out_ch.valid      = o_vld_r;
  assign out_ch.in_view    = o_view_r;
  assign out_ch.u_coord    = o_u_r;
  assign out_ch.v_coord    = o_v_r;
  assign out_ch.cam_x      = o_cx_r;
  assign out_ch.cam_y      = o_cy_r;
  assign out_ch.cam_z      = o_cz_r;
  assign out_ch.intensity  = o_int_r;
  assign out_ch.view_count = o_cnt_r;

  // A point reported in view must lie inside the depth window.
  a_view_depth: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && o_view_r |-> o_cz_r >= DEPTH_LO && o_cz_r <= DEPTH_HI)
    else $error("in-view result outside depth window");

  // The count only steps by one or restarts.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + 1'b1 || cnt_r <= 24'd1)
    else $error("in-view count jumped");

  // A frozen pipeline must not write the image store.
  a_stall_write: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> !ram_we)
    else $error("image store written during stall");

endmodule

`default_nettype wire

// File: sim/lidar_point_camera_projection_test.sv
`default_nettype none

module lidar_point_camera_projection_test;
  import lpcp_pkg::*;

  localparam int IMG_W = 1024;
  localparam int IMG_H = 512;
  localparam longint FRAC_ONE = 64'd1 << FRAC_W;
  localparam longint METER = 65536;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    bit                     action;
    bit                     first_point;
    logic [ADDR_W-1:0]      pixel_addr;
    logic [PIX_W-1:0]       pixel_value;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
  } request_t;

  typedef struct {
    bit                     in_view;
    logic [U_W-1:0]         u_coord;
    logic [V_W-1:0]         v_coord;
    logic signed [PT_W-1:0] cam_x;
    logic signed [PT_W-1:0] cam_y;
    logic signed [PT_W-1:0] cam_z;
    logic [INT_W-1:0]       intensity;
    logic [CNT_W-1:0]       view_count;
  } projection_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lpcp_cfg_if cfg_ch();
  lpcp_in_if in_ch();
  lpcp_out_if out_ch();

  lidar_point_camera_projection #(.IMG_W(IMG_W), .IMG_H(IMG_H)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_ch(cfg_ch),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  logic [CFG_DATA_W-1:0] calib [CFG_N];
  logic [PIX_W-1:0] image_copy [STORE_DEPTH];
  bit pixel_planned [STORE_DEPTH];
  logic [CNT_W-1:0] view_total;

  request_t pending_requests[$];
  projection_t expected_projections[$];
  request_t in_cur;
  bit in_taken;
  int burst_left, gap_left;
  logic [15:0] stall_pattern;
  int stall_phase;
  int error_count;
  int cycle_count;
  int point_mode;

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic longint coef(input int r, input bit hi);
    logic [31:0] w;
    w = hi ? calib[r][63:32] : calib[r][31:0];
    return longint'($signed(w));
  endfunction

  function automatic longint camera_axis(input int row, input longint px, input longint py,
                                         input longint pz);
    longint acc;
    acc = ((coef(2*row, 0) * px) >>> 8) + ((coef(2*row, 1) * py) >>> 8)
        + ((coef(2*row+1, 0) * pz) >>> 8) + coef(2*row+1, 1) * 256;
    acc = (acc + 32768) >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc;
  endfunction

  // Works out the camera frame point and, inside the depth window, the Q.20 coordinates.
  function automatic bit locate(input request_t r, output longint cx, output longint cy,
                                output longint cz, output longint u, output longint v);
    longint px, py, pz;
    px = r.point_x;
    py = r.point_y;
    pz = r.point_z;
    cx = camera_axis(0, px, py, pz);
    cy = camera_axis(1, px, py, pz);
    cz = camera_axis(2, px, py, pz);
    u = 0;
    v = 0;
    if (cz < DEPTH_LO || cz > DEPTH_HI) return 1'b0;
    u = (longint'(calib[REG_FOCAL][31:0]) * cx) / cz + longint'(calib[REG_CENTER][31:0]);
    v = (longint'(calib[REG_FOCAL][63:32]) * cy) / cz + longint'(calib[REG_CENTER][63:32]);
    return u >= 0 && u <= IMG_W * FRAC_ONE && v >= 0 && v <= IMG_H * FRAC_ONE;
  endfunction

  // Neighbour order: top left, top right, bottom left, bottom right.
  function automatic void cell_addrs(input longint u, input longint v,
                                     output logic [ADDR_W-1:0] a [4]);
    longint x0, y0, x1, y1;
    x0 = u >> FRAC_W;
    y0 = v >> FRAC_W;
    if (x0 > IMG_W - 1) x0 = IMG_W - 1;
    if (y0 > IMG_H - 1) y0 = IMG_H - 1;
    x1 = (x0 + 1 > IMG_W - 1) ? IMG_W - 1 : x0 + 1;
    y1 = (y0 + 1 > IMG_H - 1) ? IMG_H - 1 : y0 + 1;
    a[0] = ADDR_W'(y0 * IMG_W + x0);
    a[1] = ADDR_W'(y0 * IMG_W + x1);
    a[2] = ADDR_W'(y1 * IMG_W + x0);
    a[3] = ADDR_W'(y1 * IMG_W + x1);
  endfunction

  function automatic projection_t project_request(input request_t r);
    projection_t p;
    longint cx, cy, cz, u, v, uq, vq;
    longint unsigned dx, dy, acc;
    logic [ADDR_W-1:0] a [4];
    p = '{default: '0};
    if (!r.action) begin
      image_copy[r.pixel_addr] = r.pixel_value;
      p.view_count = view_total;
      return p;
    end
    if (r.first_point) view_total = '0;
    if (locate(r, cx, cy, cz, u, v)) begin
      cell_addrs(u, v, a);
      dx = u & (FRAC_ONE - 1);
      dy = v & (FRAC_ONE - 1);
      acc = (FRAC_ONE - dx) * (FRAC_ONE - dy) * image_copy[a[0]]
          + dx * (FRAC_ONE - dy) * image_copy[a[1]]
          + (FRAC_ONE - dx) * dy * image_copy[a[2]]
          + dx * dy * image_copy[a[3]];
      uq = u >> 12;
      vq = v >> 12;
      p.in_view = 1'b1;
      p.u_coord = (uq > U_MAX) ? U_MAX : U_W'(uq);
      p.v_coord = (vq > V_MAX) ? V_MAX : V_W'(vq);
      p.intensity = INT_W'((acc + 64'h8000_0000) >> 32);
      if (view_total != CNT_MAX) view_total++;
    end
    p.cam_x = PT_W'(cx);
    p.cam_y = PT_W'(cy);
    p.cam_z = PT_W'(cz);
    p.view_count = view_total;
    return p;
  endfunction

  task automatic queue_pixel(input logic [ADDR_W-1:0] addr, input logic [PIX_W-1:0] value);
    request_t r;
    r = '{default: '0};
    r.pixel_addr = addr;
    r.pixel_value = value;
    r.point_x = $urandom;
    pixel_planned[addr] = 1'b1;
    pending_requests = {pending_requests, r};
  endtask

  // Points that land in the image get their four neighbours written first.
  task automatic queue_point(input bit first, input longint x, input longint y, input longint z);
    request_t r;
    longint cx, cy, cz, u, v;
    logic [ADDR_W-1:0] a [4];
    r = '{default: '0};
    r.action = 1'b1;
    r.first_point = first;
    r.pixel_addr = ADDR_W'($urandom);
    r.pixel_value = PIX_W'($urandom);
    r.point_x = PT_W'(x);
    r.point_y = PT_W'(y);
    r.point_z = PT_W'(z);
    if (locate(r, cx, cy, cz, u, v)) begin
      cell_addrs(u, v, a);
      foreach (a[i])
        if (!pixel_planned[a[i]]) queue_pixel(a[i], PIX_W'($urandom));
    end
    pending_requests = {pending_requests, r};
  endtask

  task automatic queue_random(input int count);
    longint fwd, lat1, lat2;
    bit first;
    repeat (count) begin
      first = ($urandom_range(0, 19) == 0);
      case ($urandom_range(0, 19))
        0: queue_pixel(ADDR_W'($urandom), PIX_W'($urandom));
        1, 2: queue_point(first, $signed($urandom), $signed($urandom), $signed($urandom));
        default: begin
          fwd = $urandom_range(3 * METER, 75 * METER);
          lat1 = longint'($urandom_range(0, 2 * fwd)) - fwd;
          lat2 = longint'($urandom_range(0, 2 * fwd)) - fwd;
          if (point_mode == 0) queue_point(first, lat1, lat2, fwd);
          else queue_point(first, fwd, lat1, lat2);
        end
      endcase
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    calib[idx] = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_ch.valid || expected_projections.size() != 0);
  endtask

  function automatic logic [31:0] q24(input longint value);
    return value[31:0];
  endfunction

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Input side: accept at the rising edge, drive the next request at the falling edge.
  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (in_taken) expected_projections = {expected_projections, project_request(in_cur)};
  end

  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_requests.size() != 0) begin
        in_cur = pending_requests.pop_front();
        in_ch.action <= in_cur.action;
        in_ch.first_point <= in_cur.first_point;
        in_ch.pixel_addr <= in_cur.pixel_addr;
        in_ch.pixel_value <= in_cur.pixel_value;
        in_ch.point_x <= in_cur.point_x;
        in_ch.point_y <= in_cur.point_y;
        in_ch.point_z <= in_cur.point_z;
        in_ch.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    if (stall_phase % 64 == 0) stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
    out_ch.ready <= stall_pattern[stall_phase % 16];
    stall_phase++;
  end

  always @(posedge clk) begin
    projection_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (out_ch.valid && out_ch.ready) begin
      if (expected_projections.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = expected_projections.pop_front();
        check_field("in_view", out_ch.in_view, want.in_view);
        check_field("u_coord", out_ch.u_coord, want.u_coord);
        check_field("v_coord", out_ch.v_coord, want.v_coord);
        check_field("cam_x", out_ch.cam_x, want.cam_x);
        check_field("cam_y", out_ch.cam_y, want.cam_y);
        check_field("cam_z", out_ch.cam_z, want.cam_z);
        check_field("intensity", out_ch.intensity, want.intensity);
        check_field("view_count", out_ch.view_count, want.view_count);
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] corner [4];
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.first_point = 1'b0;
    in_ch.pixel_addr = '0;
    in_ch.pixel_value = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready = 1'b0;
    stall_pattern = '1;
    point_mode = 0;
    view_total = '0;
    foreach (calib[i]) calib[i] = CFG_RESET[i];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration: identity transform, unit focal lengths, so u = x / z.
    queue_pixel('0, 8'd0);
    queue_pixel('1, 8'd255);
    queue_point(1'b0, 0, 0, 5 * METER);
    queue_point(1'b0, 0, 0, 5 * METER - 1);
    queue_point(1'b0, 3 * METER, 2 * METER, 70 * METER);
    queue_point(1'b0, 0, 0, 70 * METER + 1);
    queue_point(1'b0, -1, 0, 10 * METER);
    queue_point(1'b1, 10 * METER, 10 * METER, 10 * METER);
    queue_point(1'b0, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    queue_point(1'b0, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    queue_point(1'b1, 0, 0, 20 * METER);
    queue_random(50);
    wait_drained();

    // Camera aligned with the point frame, 512 pixel focal length, centered.
    write_reg(REG_ROW0_A, {32'd0, q24(1 << 24)});
    write_reg(REG_ROW0_B, 64'd0);
    write_reg(REG_ROW1_A, {q24(1 << 24), 32'd0});
    write_reg(REG_ROW1_B, 64'd0);
    write_reg(REG_ROW2_A, 64'd0);
    write_reg(REG_ROW2_B, {32'd0, q24(1 << 24)});
    write_reg(REG_FOCAL, {32'd512 << FRAC_W, 32'd512 << FRAC_W});
    write_reg(REG_CENTER, {32'd256 << FRAC_W, 32'd512 << FRAC_W});
    // Exactly on the right and bottom edges, then the left and top edges.
    queue_point(1'b1, 20 * METER, 10 * METER, 20 * METER);
    queue_point(1'b0, -20 * METER, -10 * METER, 20 * METER);
    queue_point(1'b0, 20 * METER, -10 * METER, 20 * METER);
    queue_point(1'b0, 20 * METER + 64, 0, 20 * METER);
    queue_random(150);
    wait_drained();

    // Point frame x forward: camera x = -y, y = -z, z = x, small random offsets.
    point_mode = 1;
    write_reg(REG_ROW0_A, {q24(-(64'sd1 << 24)), 32'd0});
    write_reg(REG_ROW0_B, {q24(longint'($urandom_range(0, 1 << 24)) - (1 << 23)), 32'd0});
    write_reg(REG_ROW1_A, 64'd0);
    write_reg(REG_ROW1_B, {q24(longint'($urandom_range(0, 1 << 24)) - (1 << 23)),
                           q24(-(64'sd1 << 24))});
    write_reg(REG_ROW2_A, {32'd0, q24(1 << 24)});
    write_reg(REG_ROW2_B, {q24(longint'($urandom_range(0, 1 << 24)) - (1 << 23)), 32'd0});
    write_reg(REG_FOCAL, {32'($urandom_range(300, 900)) << FRAC_W,
                          32'($urandom_range(300, 900)) << FRAC_W});
    write_reg(REG_CENTER, {32'($urandom_range(200, 300) << FRAC_W) | 32'($urandom_range(0, 1 << 20)),
                           32'($urandom_range(450, 570) << FRAC_W) | 32'($urandom_range(0, 1 << 20))});
    queue_random(150);
    wait_drained();

    // Extreme register contents, twice.
    corner[0] = '0;
    corner[1] = '1;
    corner[2] = 64'h8000_0000_7FFF_FFFF;
    corner[3] = 64'h7FFF_FFFF_8000_0000;
    repeat (2) begin
      for (int i = 0; i < CFG_N; i++) write_reg(cfg_reg_t'(i), corner[$urandom_range(0, 3)]);
      point_mode = $urandom_range(0, 1);
      queue_random(40);
      wait_drained();
    end

    // Back to the reset values, which also cover the middle of each range.
    for (int i = 0; i < CFG_N; i++) write_reg(cfg_reg_t'(i), CFG_RESET[i]);
    point_mode = 0;
    queue_random(30);
    wait_drained();

    repeat (60) @(posedge clk);
    if (expected_projections.size() != 0) report("results still outstanding at the end");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
design/lpcp_pkg.sv
design/lpcp_if.sv
design/lpcp_ram.sv
design/lpcp_div.sv
design/lidar_point_camera_projection.sv
sim/lidar_point_camera_projection_test.sv
